@@ sv/ttb_pkg.sv @@
// Shared constants, the setup-to-walk job record and the tile index helper
// for the triangle tile binner. No dependencies.
package ttb_pkg;

  localparam int FracBits = 16;
  localparam int MaxTiles = 8;
  localparam int CoordW   = 32;
  localparam int NdcBits  = 28;
  localparam int VW       = NdcBits + 2;        // saturated projected coordinate
  localparam int DvdW     = CoordW + FracBits;  // dividend and quotient width
  localparam int DivCntW  = $clog2(DvdW + 1);
  localparam int DifW     = VW + 1;             // coordinate difference
  localparam int ProdW    = 2 * DifW;
  localparam int AreaW    = ProdW + 1;
  localparam int TileW    = 4;                  // tile index, may hold MaxTiles
  localparam int MulW     = 6;                  // signed corner multiplier
  localparam int EdgeW    = AreaW + 5;          // scaled edge function
  localparam int QDepth   = 2;

  localparam logic signed [VW:0] OneX = (VW + 1)'(1) <<< FracBits;

  typedef struct packed {
    logic [15:0]                  prim_id;
    logic [2:0][DifW-1:0]         ea;
    logic [2:0][DifW-1:0]         eb;
    logic [2:0][EdgeW-1:0]        enk;
    logic [TileW-1:0]             c0;
    logic [TileW-1:0]             c1;
    logic [TileW-1:0]             r0;
    logic [TileW-1:0]             r1;
    logic [TileW-1:0]             n;
  } job_t;

  // Tile index of a coordinate, limited to lim.
  function automatic logic [TileW-1:0] tile_of(input logic signed [VW-1:0] v,
                                               input logic [TileW-1:0] n,
                                               input logic [TileW-1:0] lim);
    logic signed [VW:0]     t;
    logic [VW+TileW-1:0]    p;
    logic [VW+TileW-1:0]    q;
    t = {v[VW-1], v} + OneX;
    p = (VW + TileW)'(t[VW-1:0]) * (VW + TileW)'(n);
    q = p >> (FracBits + 1);
    if (t <= 0) begin
      return '0;
    end else if (q > (VW + TileW)'(lim)) begin
      return lim;
    end
    return q[TileW-1:0];
  endfunction

endpackage

@@ sv/ttb_if.sv @@
// Handshake interfaces for the triangle input channel and the tile output
// channel. No dependencies.
interface ttb_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x, a_y, a_z, a_w;
  logic signed [31:0] b_x, b_y, b_z, b_w;
  logic signed [31:0] c_x, c_y, c_z, c_w;

  modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  c_x, c_y, c_z, c_w, input ready);
  modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                c_x, c_y, c_z, c_w, output ready);
endinterface

interface ttb_tile_if;
  logic        valid;
  logic        ready;
  logic [15:0] prim_id;
  logic [2:0]  tile_col;
  logic [2:0]  tile_row;
  logic        full_cover;
  logic        last_tile;

  modport source (output valid, prim_id, tile_col, tile_row, full_cover, last_tile,
                  input ready);
  modport sink (input valid, prim_id, tile_col, tile_row, full_cover, last_tile,
                output ready);
endinterface

@@ sv/ttb_div.sv @@
// One lane of the restoring divider, one quotient bit per cycle while step_i is high.
// Depends on ttb_pkg.
module ttb_div (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic                          step_i,
  input  logic [ttb_pkg::DvdW-1:0]      dvd_i,
  input  logic [ttb_pkg::CoordW-2:0]    dvs_i,
  output logic [ttb_pkg::DvdW-1:0]      quo_o
);
  import ttb_pkg::*;

  logic [CoordW-2:0] rem_q, rem_d;
  logic [DvdW-1:0]   dq_q, dq_d;
  logic [CoordW-1:0] trial;
  logic              fits;

  always_comb begin
    trial = {rem_q, dq_q[DvdW-1]};
    fits  = trial >= {1'b0, dvs_i};
    rem_d = fits ? (CoordW-1)'(trial - {1'b0, dvs_i}) : trial[CoordW-2:0];
    dq_d  = {dq_q[DvdW-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      dq_q  <= dvd_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign quo_o = dq_q;
endmodule

@@ sv/ttb_front.sv @@
// Triangle setup: projection by w, rejection of non-positive w, bounding-box and
// back-face rejection, edge coefficients and tile range. Depends on ttb_pkg, ttb_if and ttb_div.
module ttb_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  ttb_tri_if.sink                 tri_i,
  input  logic [3:0]              tiles_i,
  output logic                    job_valid_o,
  input  logic                    job_ready_i,
  output ttb_pkg::job_t           job_o
);
  import ttb_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StBox  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StPush = 3'd4;

  localparam logic [DvdW-1:0]      SatLim = DvdW'(1) << NdcBits;
  localparam logic signed [VW-1:0] OneV   = VW'(1) <<< FracBits;

  logic [2:0]          state_q, state_d;
  logic [DivCntW-1:0]  cnt_q;
  logic [15:0]         id_cnt_q, id_q;
  logic [TileW-1:0]    n_q, n_in;
  logic [8:0]          neg_q;
  logic [CoordW-2:0]   w_q [3];

  logic signed [31:0]  crd [9];
  logic signed [31:0]  w_in [3];
  logic [DvdW-1:0]     dvd [9];
  logic [DvdW-1:0]     quo [9];
  logic signed [VW-1:0] vs [9];
  logic [31:0]         mag [9];
  logic [VW-1:0]       smag [9];

  logic signed [VW-1:0] vx_q [3], vy_q [3];
  logic signed [VW-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic signed [VW-1:0] minx, maxx, miny, maxy, minz, maxz;
  logic                 box_out;

  logic signed [DifW-1:0] ea [3], eb [3];
  logic signed [DifW-1:0] d1x, d1y, d2x, d2y, op_a, op_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AreaW-1:0] acc_q, adiff, ksum;
  logic signed [EdgeW-1:0] nkv;
  logic signed [EdgeW-1:0] nk_q [3];
  logic                    area_neg_q;

  logic accept, w_bad;

  assign tri_i.ready = (state_q == StIdle);
  assign accept      = tri_i.valid && tri_i.ready;

  always_comb begin
    crd[0] = tri_i.a_x; crd[1] = tri_i.a_y; crd[2] = tri_i.a_z;
    crd[3] = tri_i.b_x; crd[4] = tri_i.b_y; crd[5] = tri_i.b_z;
    crd[6] = tri_i.c_x; crd[7] = tri_i.c_y; crd[8] = tri_i.c_z;
    w_in[0] = tri_i.a_w; w_in[1] = tri_i.b_w; w_in[2] = tri_i.c_w;
    w_bad = 1'b0;
    for (int v = 0; v < 3; v++) begin
      if (w_in[v] <= 0) w_bad = 1'b1;
    end
    if (tiles_i == '0) begin
      n_in = TileW'(1);
    end else if (tiles_i > TileW'(MaxTiles)) begin
      n_in = TileW'(MaxTiles);
    end else begin
      n_in = tiles_i;
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_lane
    assign mag[l] = crd[l][31] ? 32'(-crd[l]) : 32'(crd[l]);
    assign dvd[l] = {mag[l], {FracBits{1'b0}}};
    ttb_div u_div (
      .clk_i  (clk_i),
      .load_i (accept),
      .step_i (state_q == StDiv),
      .dvd_i  (dvd[l]),
      .dvs_i  (w_q[l / 3]),
      .quo_o  (quo[l])
    );
    // Saturate the magnitude, then restore the sign (quotient truncates toward zero).
    assign smag[l] = (quo[l] > SatLim) ? SatLim[VW-1:0] : quo[l][VW-1:0];
    assign vs[l]   = neg_q[l] ? -$signed(smag[l]) : $signed(smag[l]);
  end

  always_comb begin
    minx = vs[0]; maxx = vs[0];
    miny = vs[1]; maxy = vs[1];
    minz = vs[2]; maxz = vs[2];
    for (int v = 1; v < 3; v++) begin
      if (vs[3*v] < minx)   minx = vs[3*v];
      if (vs[3*v] > maxx)   maxx = vs[3*v];
      if (vs[3*v+1] < miny) miny = vs[3*v+1];
      if (vs[3*v+1] > maxy) maxy = vs[3*v+1];
      if (vs[3*v+2] < minz) minz = vs[3*v+2];
      if (vs[3*v+2] > maxz) maxz = vs[3*v+2];
    end
    box_out = (maxz < 0) || (minz > OneV) || (maxx < -OneV) || (minx > OneV) ||
              (maxy < -OneV) || (miny > OneV);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea[i] = DifW'(vy_q[(i + 1) % 3]) - DifW'(vy_q[i]);
      eb[i] = DifW'(vx_q[i]) - DifW'(vx_q[(i + 1) % 3]);
    end
    d1x = DifW'(vx_q[1]) - DifW'(vx_q[0]);
    d1y = DifW'(vy_q[1]) - DifW'(vy_q[0]);
    d2x = DifW'(vx_q[2]) - DifW'(vx_q[0]);
    d2y = DifW'(vy_q[2]) - DifW'(vy_q[0]);
    case (cnt_q)
      DivCntW'(0): begin op_a = d1x;   op_b = d2y; end
      DivCntW'(1): begin op_a = d2x;   op_b = d1y; end
      DivCntW'(2): begin op_a = ea[0]; op_b = DifW'(vx_q[0]); end
      DivCntW'(3): begin op_a = eb[0]; op_b = DifW'(vy_q[0]); end
      DivCntW'(4): begin op_a = ea[1]; op_b = DifW'(vx_q[1]); end
      DivCntW'(5): begin op_a = eb[1]; op_b = DifW'(vy_q[1]); end
      DivCntW'(6): begin op_a = ea[2]; op_b = DifW'(vx_q[2]); end
      default:     begin op_a = eb[2]; op_b = DifW'(vy_q[2]); end
    endcase
    adiff = acc_q - AreaW'(prod_q);
    ksum  = acc_q + AreaW'(prod_q);
    nkv   = EdgeW'(ksum) * EdgeW'($signed({1'b0, n_q}));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept && !w_bad) state_d = StDiv;
      StDiv:   if (cnt_q == DivCntW'(DvdW - 1)) state_d = StBox;
      StBox:   state_d = box_out ? StIdle : StMul;
      StMul:   if (cnt_q == DivCntW'(8)) state_d = area_neg_q ? StIdle : StPush;
      StPush:  if (job_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      id_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) id_cnt_q <= id_cnt_q + 16'd1;
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else if (state_q == StDiv || state_q == StMul) begin
        cnt_q <= cnt_q + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q <= id_cnt_q;
      n_q  <= n_in;
      for (int l = 0; l < 9; l++) neg_q[l] <= crd[l][31];
      for (int v = 0; v < 3; v++) w_q[v] <= w_in[v][CoordW-2:0];
    end
    if (state_q == StBox) begin
      for (int v = 0; v < 3; v++) begin
        vx_q[v] <= vs[3*v];
        vy_q[v] <= vs[3*v+1];
      end
      minx_q <= minx; maxx_q <= maxx;
      miny_q <= miny; maxy_q <= maxy;
    end
    if (state_q == StMul) begin
      prod_q <= op_a * op_b;
      case (cnt_q)
        DivCntW'(1): acc_q <= AreaW'(prod_q);
        DivCntW'(2): area_neg_q <= adiff[AreaW-1];
        DivCntW'(3): acc_q <= AreaW'(prod_q);
        DivCntW'(4): nk_q[0] <= nkv;
        DivCntW'(5): acc_q <= AreaW'(prod_q);
        DivCntW'(6): nk_q[1] <= nkv;
        DivCntW'(7): acc_q <= AreaW'(prod_q);
        DivCntW'(8): nk_q[2] <= nkv;
        default: ;
      endcase
    end
  end

  assign job_valid_o = (state_q == StPush);

  always_comb begin
    job_o.prim_id = id_q;
    for (int i = 0; i < 3; i++) begin
      job_o.ea[i]  = ea[i];
      job_o.eb[i]  = eb[i];
      job_o.enk[i] = nk_q[i];
    end
    job_o.c0 = tile_of(minx_q, n_q, TileW'(MaxTiles));
    job_o.c1 = tile_of(maxx_q, n_q, n_q - TileW'(1));
    job_o.r0 = tile_of(miny_q, n_q, TileW'(MaxTiles));
    job_o.r1 = tile_of(maxy_q, n_q, n_q - TileW'(1));
    job_o.n  = n_q;
  end
endmodule

@@ sv/ttb_fifo.sv @@
// Small register queue of setup jobs between setup and tile walk.
// Depends on ttb_pkg.
module ttb_fifo #(
  parameter int DEPTH = ttb_pkg::QDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ttb_pkg::job_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ttb_pkg::job_t  pop_data_o
);
  import ttb_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end
endmodule

@@ sv/ttb_back.sv @@
// Tile walk: tests each tile of the box, one edge per cycle unless output stalls,
// and emits kept tiles through an output register. Depends on ttb_pkg and ttb_if.
module ttb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  ttb_pkg::job_t  job_i,
  ttb_tile_if.source     tile_o
);
  import ttb_pkg::*;

  localparam logic [1:0] BIdle  = 2'd0;
  localparam logic [1:0] BEval  = 2'd1;
  localparam logic [1:0] BFlush = 2'd2;

  logic [1:0]        state_q;
  job_t              job_q;
  logic [TileW-1:0]  col_q, row_q;
  logic [1:0]        e_q;
  logic              keep_q, full_q;
  logic              pend_valid_q, pend_full_q;
  logic [2:0]        pend_col_q, pend_row_q;
  logic              out_valid_q;

  logic signed [DifW-1:0]  a, b;
  logic signed [EdgeW-1:0] nk, ein, eout;
  logic signed [MulW-1:0]  mcl, mcr, mrt, mrb, mxi, mxo, myi, myo;
  logic signed [DifW+MulW:0] lin, lout;
  logic keep_now, full_now, can_push, last_e, stall, push_pend, take;

  assign job_ready_o = (state_q == BIdle);
  assign take        = job_valid_i && job_ready_o;
  assign can_push    = !out_valid_q || tile_o.ready;

  always_comb begin
    a   = $signed(job_q.ea[e_q]);
    b   = $signed(job_q.eb[e_q]);
    nk  = $signed(job_q.enk[e_q]);
    mcl = $signed({1'b0, col_q, 1'b0}) - $signed({2'b0, job_q.n});
    mcr = mcl + MulW'(2);
    mrt = $signed({1'b0, row_q, 1'b0}) - $signed({2'b0, job_q.n});
    mrb = mrt + MulW'(2);
    // The inside corner lies toward the negative side of the edge.
    mxi = (a > 0) ? mcl : mcr;
    mxo = (a > 0) ? mcr : mcl;
    myi = (b > 0) ? mrt : mrb;
    myo = (b > 0) ? mrb : mrt;
    lin  = (DifW+MulW+1)'(a * mxi) + (DifW+MulW+1)'(b * myi);
    lout = (DifW+MulW+1)'(a * mxo) + (DifW+MulW+1)'(b * myo);
    ein  = (EdgeW'(lin) <<< FracBits) - nk;
    eout = (EdgeW'(lout) <<< FracBits) - nk;
    keep_now  = keep_q && (ein < 0);
    full_now  = full_q && (eout < 0);
    last_e    = (e_q == 2'd2);
    stall     = keep_now && pend_valid_q && !can_push;
    push_pend = (state_q == BEval && last_e && keep_now && pend_valid_q && can_push) ||
                (state_q == BFlush && pend_valid_q && can_push);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BIdle;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push_pend) begin
        out_valid_q <= 1'b1;
      end else if (tile_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BIdle: begin
          if (take && job_i.c0 <= job_i.c1 && job_i.r0 <= job_i.r1) state_q <= BEval;
        end
        BEval: begin
          if (last_e && !stall) begin
            if (keep_now) pend_valid_q <= 1'b1;
            if (col_q == job_q.c1 && row_q == job_q.r1) state_q <= BFlush;
          end
        end
        BFlush: begin
          if (!pend_valid_q) begin
            state_q <= BIdle;
          end else if (can_push) begin
            pend_valid_q <= 1'b0;
            state_q      <= BIdle;
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q  <= job_i;
      col_q  <= job_i.c0;
      row_q  <= job_i.r0;
      e_q    <= 2'd0;
      keep_q <= 1'b1;
      full_q <= 1'b1;
    end else if (state_q == BEval) begin
      if (!last_e) begin
        e_q    <= e_q + 2'd1;
        keep_q <= keep_now;
        full_q <= full_now;
      end else if (!stall) begin
        e_q    <= 2'd0;
        keep_q <= 1'b1;
        full_q <= 1'b1;
        if (keep_now) begin
          pend_col_q  <= col_q[2:0];
          pend_row_q  <= row_q[2:0];
          pend_full_q <= full_now;
        end
        if (col_q == job_q.c1) begin
          col_q <= job_q.c0;
          row_q <= row_q + TileW'(1);
        end else begin
          col_q <= col_q + TileW'(1);
        end
      end
    end
    if (push_pend) begin
      tile_o.prim_id    <= job_q.prim_id;
      tile_o.tile_col   <= pend_col_q;
      tile_o.tile_row   <= pend_row_q;
      tile_o.full_cover <= pend_full_q;
      tile_o.last_tile  <= (state_q == BFlush);
    end
  end

  assign tile_o.valid = out_valid_q;
endmodule

@@ sv/triangle_tile_binner_core.sv @@
// Triangle tile binner: setup steps through accepting the triangle, the divider, the
// box check, the multiplies and the hand-off to the queue. A triangle whose box misses
// the screen or depth range leaves after the box check, a back face after the
// multiplies, and one with some w not positive is dropped at accept. The tile walk takes
// a job, tests each tile of the box edge by edge and ends with a flush. A kept tile is
// held until the next kept tile is found or the walk ends.
// Setup takes a new triangle only when idle, so it sets the rate while it is the longer
// part; a large box or output stalls can make the walk the limit instead.
// Reset (rst_ni, asynchronous, active low) empties the queue, zeroes the id
// counter and sets tiles_q to 8.
module triangle_tile_binner_core #(
  parameter int QUEUE_DEPTH = ttb_pkg::QDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttb_tri_if.sink    tri_i,
  ttb_tile_if.source tile_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);
  import ttb_pkg::*;

  // Tile count register; the user must write it only while the block is idle, which the block itself does not enforce.
  logic [3:0] tiles_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_q <= 4'd8;
    end else if (cfg_we_i) begin
      tiles_q <= cfg_wdata_i;
    end
  end

  // The setup front end accepts a triangle only when it is idle; every
  // accepted transfer takes the next primitive id, even when rejected.
  logic job_in_valid, job_in_ready, job_out_valid, job_out_ready;
  job_t job_in, job_out;

  ttb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_i       (tri_i),
    .tiles_i     (tiles_q),
    .job_valid_o (job_in_valid),
    .job_ready_i (job_in_ready),
    .job_o       (job_in)
  );

  // The queue lets setup of the next triangle overlap the tile walk.
  ttb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_in_valid),
    .push_ready_o (job_in_ready),
    .push_data_i  (job_in),
    .pop_valid_o  (job_out_valid),
    .pop_ready_i  (job_out_ready),
    .pop_data_o   (job_out)
  );

  // The walk holds back one kept tile so that the final one of a triangle
  // can be marked; results leave through a registered output transfer.
  ttb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_out_valid),
    .job_ready_o (job_out_ready),
    .job_i       (job_out),
    .tile_o      (tile_o)
  );
endmodule

@@ tb/tb.sv @@
// Self-checking bench for triangle_tile_binner_core: drives triangles, predicts
// the emitted tiles and checks every tile transfer field by field.
// Depends on sv/ttb_pkg.sv, sv/ttb_if.sv and sv/triangle_tile_binner_core.sv.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic signed [31:0] a_x, a_y, a_z, a_w;
    logic signed [31:0] b_x, b_y, b_z, b_w;
    logic signed [31:0] c_x, c_y, c_z, c_w;
  } triangle_t;

  typedef struct packed {
    logic [15:0] prim_id;
    logic [2:0]  tile_col;
    logic [2:0]  tile_row;
    logic        full_cover;
    logic        last_tile;
  } tile_t;

  localparam longint One       = 64'sd1 <<< ttb_pkg::FracBits;
  localparam longint NdcLimit  = 64'sd1 <<< ttb_pkg::NdcBits;
  localparam int     DrainWait = 1000;
  localparam longint CycleLimit = 2_000_000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  ttb_tri_if  tri_bus ();
  ttb_tile_if tile_bus ();

  triangle_tile_binner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_i       (tri_bus),
    .tile_o      (tile_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Bench-side copy of the block state.
  logic [3:0]  grid_reg;
  logic [15:0] prim_ctr;

  triangle_t pending_tris[$];
  tile_t     tile_expect[$];

  int     errors;
  int     tiles_seen;
  int     tris_sent;
  int     full_seen;
  bit     no_idle;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (tile transfer %0d)", what, got, want,
             tiles_seen);
    errors++;
  endtask

  function automatic longint project_coord(input longint c, input longint w);
    longint q;
    q = (c * One) / w;
    if (q > NdcLimit) q = NdcLimit;
    if (q < -NdcLimit) q = -NdcLimit;
    return q;
  endfunction

  function automatic longint tile_index(input longint v, input longint n);
    longint t;
    t = v + One;
    if (t <= 0) return 0;
    return (t * n) / (2 * One);
  endfunction

  // Works out the tiles one accepted triangle produces and queues them in order.
  task automatic predict_tiles(input triangle_t t);
    longint raw[12];
    longint vx[3], vy[3], vz[3];
    longint minx, maxx, miny, maxy, minz, maxz, area, n;
    longint c0, c1, r0, r1, ea, eb, ex, ey, ox, oy, e_in, e_out;
    longint left, right, top, bottom;
    logic [15:0] id;
    tile_t found[$];
    tile_t one_tile;
    bit keep, full;
    int j;

    raw = '{t.a_x, t.a_y, t.a_z, t.a_w, t.b_x, t.b_y, t.b_z, t.b_w,
            t.c_x, t.c_y, t.c_z, t.c_w};
    id = prim_ctr;
    prim_ctr++;
    for (int i = 0; i < 3; i++) begin
      if (raw[i*4+3] <= 0) return;
      vx[i] = project_coord(raw[i*4], raw[i*4+3]);
      vy[i] = project_coord(raw[i*4+1], raw[i*4+3]);
      vz[i] = project_coord(raw[i*4+2], raw[i*4+3]);
    end
    minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0]; minz = vz[0]; maxz = vz[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < minx) minx = vx[i];
      if (vx[i] > maxx) maxx = vx[i];
      if (vy[i] < miny) miny = vy[i];
      if (vy[i] > maxy) maxy = vy[i];
      if (vz[i] < minz) minz = vz[i];
      if (vz[i] > maxz) maxz = vz[i];
    end
    if (maxz < 0 || minz > One) return;
    if (maxx < -One || minx > One) return;
    if (maxy < -One || miny > One) return;
    area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[1] - vy[0]);
    if (area < 0) return;

    n = grid_reg;
    if (n < 1) n = 1;
    if (n > ttb_pkg::MaxTiles) n = ttb_pkg::MaxTiles;
    c0 = tile_index(minx, n);
    r0 = tile_index(miny, n);
    c1 = tile_index(maxx, n);
    r1 = tile_index(maxy, n);
    if (c1 > n - 1) c1 = n - 1;
    if (r1 > n - 1) r1 = n - 1;

    for (longint row = r0; row <= r1; row++) begin
      for (longint col = c0; col <= c1; col++) begin
        left   = (2 * col - n) * One;
        right  = (2 * col + 2 - n) * One;
        top    = (2 * row - n) * One;
        bottom = (2 * row + 2 - n) * One;
        keep = 1'b1;
        full = 1'b1;
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          ea = vy[j] - vy[i];
          eb = vx[i] - vx[j];
          // The corner nearest the inside of the edge decides rejection, the
          // farthest one decides full coverage. Both are scaled by the tile count.
          ex = (ea > 0) ? left : right;
          ey = (eb > 0) ? top : bottom;
          ox = (ea > 0) ? right : left;
          oy = (eb > 0) ? bottom : top;
          e_in  = ea * (ex - n * vx[i]) + eb * (ey - n * vy[i]);
          e_out = ea * (ox - n * vx[i]) + eb * (oy - n * vy[i]);
          if (e_in >= 0) keep = 1'b0;
          if (e_out >= 0) full = 1'b0;
        end
        if (keep) begin
          one_tile.prim_id    = id;
          one_tile.tile_col   = col[2:0];
          one_tile.tile_row   = row[2:0];
          one_tile.full_cover = full;
          one_tile.last_tile  = 1'b0;
          found = {found, one_tile};
        end
      end
    end
    if (found.size() > 0) found[found.size()-1].last_tile = 1'b1;
    foreach (found[k]) tile_expect = {tile_expect, found[k]};
  endtask

  // Builds a triangle from normalized coordinates, all vertices sharing one w.
  function automatic triangle_t from_ndc(input real ax, ay, bx, by, cx, cy, z,
                                         input longint w_raw);
    triangle_t t;
    t.a_x = $rtoi(ax * w_raw); t.a_y = $rtoi(ay * w_raw);
    t.b_x = $rtoi(bx * w_raw); t.b_y = $rtoi(by * w_raw);
    t.c_x = $rtoi(cx * w_raw); t.c_y = $rtoi(cy * w_raw);
    t.a_z = $rtoi(z * w_raw); t.b_z = t.a_z; t.c_z = t.a_z;
    t.a_w = 32'(w_raw); t.b_w = 32'(w_raw); t.c_w = 32'(w_raw);
    return t;
  endfunction

  function automatic real rand_real(input real lo, input real hi);
    return lo + (hi - lo) * ($urandom_range(0, 100000) / 100000.0);
  endfunction

  // Mostly small front-facing triangles near the screen, some large ones, a
  // share of back faces, broken w or z, and pure noise in every bit.
  function automatic triangle_t random_triangle();
    triangle_t t;
    real mx, my, sz, ax, ay, bx, by, cx, cy, winding;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return t;
    end
    mx = rand_real(-1.3, 1.3);
    my = rand_real(-1.3, 1.3);
    sz = ($urandom_range(0, 7) == 0) ? rand_real(0.5, 3.0) : rand_real(0.02, 0.4);
    ax = mx + rand_real(-sz, sz); ay = my + rand_real(-sz, sz);
    bx = mx + rand_real(-sz, sz); by = my + rand_real(-sz, sz);
    cx = mx + rand_real(-sz, sz); cy = my + rand_real(-sz, sz);
    winding = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    if (winding < 0 && $urandom_range(0, 7) != 0)
      t = from_ndc(ax, ay, cx, cy, bx, by, rand_real(0.0, 1.0),
                   $urandom_range(16384, 262144));
    else
      t = from_ndc(ax, ay, bx, by, cx, cy, rand_real(0.0, 1.0),
                   $urandom_range(16384, 262144));
    // Per-vertex w and z variation keeps the divider busy on distinct values.
    t.b_w = t.b_w + $urandom_range(0, 255);
    t.c_z = t.c_z + $signed($urandom_range(0, 4095)) - 2048;
    if (kind < 14) t.c_w = -32'($urandom_range(0, 65536));
    else if (kind < 17) begin
      t.a_z = t.a_w * 2; t.b_z = t.b_w * 2; t.c_z = t.c_w * 2;
    end
    return t;
  endfunction

  task automatic load_directed();
    triangle_t t;
    t = {12{32'sh7fffffff}}; pending_tris = {pending_tris, t};
    t = {12{32'sh80000000}}; pending_tris = {pending_tris, t};
    t = '0;                  pending_tris = {pending_tris, t};
    // Screen-covering triangle in both windings: one gives full tiles, one is a back face.
    pending_tris = {pending_tris, from_ndc(-3.0, -3.0, 3.0, -3.0, 0.0, 4.0, 0.5, One)};
    pending_tris = {pending_tris, from_ndc(-3.0, -3.0, 0.0, 4.0, 3.0, -3.0, 0.5, One)};
    pending_tris = {pending_tris, from_ndc(0.1, 0.1, 0.2, 0.1, 0.1, 0.2, 0.3, One)};
    pending_tris = {pending_tris, from_ndc(0.1, 0.1, 0.1, 0.2, 0.2, 0.1, 0.3, One)};
    // Two coincident vertices give a degenerate edge.
    pending_tris = {pending_tris, from_ndc(-0.5, -0.5, -0.5, -0.5, 0.5, 0.5, 0.3, One)};
    // Depth and screen rejection, and depth exactly at its limits.
    pending_tris = {pending_tris, from_ndc(-0.5, -0.5, 0.5, -0.5, 0.0, 0.5, 2.0, One)};
    pending_tris = {pending_tris, from_ndc(-0.5, -0.5, 0.5, -0.5, 0.0, 0.5, -0.5, One)};
    pending_tris = {pending_tris, from_ndc(-0.5, -0.5, 0.5, -0.5, 0.0, 0.5, 1.0, One)};
    pending_tris = {pending_tris, from_ndc(-0.5, -0.5, 0.5, -0.5, 0.0, 0.5, 0.0, One)};
    pending_tris = {pending_tris, from_ndc(1.5, -0.5, 2.5, -0.5, 2.0, 0.5, 0.5, One)};
    pending_tris = {pending_tris, from_ndc(-0.5, -2.5, 0.5, -2.5, 0.0, -1.5, 0.5, One)};
    // Vertices on the screen border and on tile corners.
    pending_tris = {pending_tris, from_ndc(-1.0, -1.0, 1.0, -1.0, -1.0, 1.0, 0.5, One)};
    pending_tris = {pending_tris, from_ndc(-1.0, -1.0, -1.0, 1.0, 1.0, -1.0, 0.5, One)};
    // Tiny w with extreme coordinates saturates the projection.
    t = '{a_x: 32'sh80000000, a_y: 32'sh80000000, a_z: 0, a_w: 1,
          b_x: 32'sh7fffffff, b_y: 32'sh80000000, b_z: 0, b_w: 1,
          c_x: 0, c_y: 32'sh7fffffff, c_z: 0, c_w: 1};
    pending_tris = {pending_tris, t};
    t.b_x = 0; t.c_x = 32'sh7fffffff;
    pending_tris = {pending_tris, t};
    // One vertex with w of zero, one with a negative w.
    t = from_ndc(-0.5, -0.5, 0.5, -0.5, 0.0, 0.5, 0.5, One);
    t.b_w = 0;
    pending_tris = {pending_tris, t};
    t.b_w = 32'(One); t.c_w = -32'(One);
    pending_tris = {pending_tris, t};
  endtask

  // Driver: presents queued triangles, holding each until its transfer, with
  // random gaps between them.
  int        send_gap;
  triangle_t in_flight;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_bus.valid <= 1'b0;
      tri_bus.a_x <= '0; tri_bus.a_y <= '0; tri_bus.a_z <= '0; tri_bus.a_w <= '0;
      tri_bus.b_x <= '0; tri_bus.b_y <= '0; tri_bus.b_z <= '0; tri_bus.b_w <= '0;
      tri_bus.c_x <= '0; tri_bus.c_y <= '0; tri_bus.c_z <= '0; tri_bus.c_w <= '0;
      send_gap = 0;
    end else begin
      if (tri_bus.valid && tri_bus.ready) begin
        predict_tiles(in_flight);
        tris_sent++;
      end
      if (!tri_bus.valid || tri_bus.ready) begin
        if (send_gap > 0 && !no_idle) begin
          send_gap--;
          tri_bus.valid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          in_flight = pending_tris.pop_front();
          tri_bus.valid <= 1'b1;
          tri_bus.a_x <= in_flight.a_x; tri_bus.a_y <= in_flight.a_y;
          tri_bus.a_z <= in_flight.a_z; tri_bus.a_w <= in_flight.a_w;
          tri_bus.b_x <= in_flight.b_x; tri_bus.b_y <= in_flight.b_y;
          tri_bus.b_z <= in_flight.b_z; tri_bus.b_w <= in_flight.b_w;
          tri_bus.c_x <= in_flight.c_x; tri_bus.c_y <= in_flight.c_y;
          tri_bus.c_z <= in_flight.c_z; tri_bus.c_w <= in_flight.c_w;
          if ($urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          tri_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each tile transfer against the oldest prediction and
  // stalls the output in random bursts.
  int    stall_left;
  tile_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (tile_bus.valid && tile_bus.ready) begin
        tiles_seen++;
        if (tile_expect.size() == 0) begin
          report_mismatch("unexpected tile, prim_id", tile_bus.prim_id, -1);
        end else begin
          want = tile_expect.pop_front();
          if (tile_bus.full_cover) full_seen++;
          if (tile_bus.prim_id !== want.prim_id)
            report_mismatch("prim_id", tile_bus.prim_id, want.prim_id);
          if (tile_bus.tile_col !== want.tile_col)
            report_mismatch("tile_col", tile_bus.tile_col, want.tile_col);
          if (tile_bus.tile_row !== want.tile_row)
            report_mismatch("tile_row", tile_bus.tile_row, want.tile_row);
          if (tile_bus.full_cover !== want.full_cover)
            report_mismatch("full_cover", tile_bus.full_cover, want.full_cover);
          if (tile_bus.last_tile !== want.last_tile)
            report_mismatch("last_tile", tile_bus.last_tile, want.last_tile);
        end
      end
      if (no_idle) begin
        tile_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        tile_bus.ready <= 1'b0;
      end else begin
        tile_bus.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d tiles still expected", cycles,
               tile_expect.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Waits until every triangle is sent and every tile has arrived, then lets
  // the block finish any triangle that produces no tiles.
  task automatic drain();
    while (pending_tris.size() > 0 || tri_bus.valid || tile_expect.size() > 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_grid(input logic [3:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    grid_reg  = value;
  endtask

  logic [3:0] grid_plan[8];

  initial begin
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    grid_reg   = 4'd8;
    prim_ctr   = '0;
    errors     = 0;
    tiles_seen = 0;
    tris_sent  = 0;
    full_seen  = 0;
    no_idle    = 1'b0;
    cycles     = 0;
    // Grid sizes per phase: the normal maximum, the smallest, zero and the
    // largest register value (both clamped), then ordinary sizes.
    grid_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'($urandom_range(1, 8)), 4'd4};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 8; phase++) begin
      write_grid(grid_plan[phase]);
      if (phase == 0) load_directed();
      // The final phase runs both sides at full rate.
      if (phase == 7) no_idle = 1'b1;
      for (int k = 0; k < ((phase == 0) ? 40 : 55); k++)
        pending_tris = {pending_tris, random_triangle()};
      drain();
    end

    $display("Sent %0d triangles over 8 grid settings (0, 1, 3, 4, 5, 8, 15 among them);",
             tris_sent);
    $display("checked %0d tile transfers, %0d of them fully covered.", tiles_seen, full_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ttb_pkg.sv
sv/ttb_if.sv
sv/ttb_div.sv
sv/ttb_front.sv
sv/ttb_fifo.sv
sv/ttb_back.sv
sv/triangle_tile_binner_core.sv
tb/tb.sv
